[src/tpm_pkg.sv]
// Shared types, constants and position helpers for the tour mutation block.
package tpm_pkg;

  localparam int DEF_MAX_CITIES = 64;
  localparam int POS_W          = 6;
  localparam int GENE_W         = 7;
  localparam int CNT_W          = 7;
  localparam int MOD_STEPS      = 6;
  localparam int CQ_DEPTH       = 2;
  localparam int OQ_DEPTH       = 4;

  localparam logic [CNT_W-1:0] CITY_COUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0] MIN_CITIES     = 7'd4;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_PAIR  = 2'd1;
  localparam logic [1:0] KIND_BLOCK = 2'd2;
  localparam logic [1:0] KIND_INV   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SWAP = 2'd1,
    OP_INV  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [GENE_W-1:0] gene;
    logic [POS_W-1:0]  load_pos;
    logic [POS_W-1:0]  wa;
    logic [POS_W-1:0]  wb;
    logic [POS_W-1:0]  wi;
    logic [POS_W-1:0]  len;
    logic [CNT_W-1:0]  n;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [GENE_W-1:0] gene;
    logic              last;
  } res_t;

  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [POS_W-1:0] top;
    top = POS_W'(n - 7'd1);
    return (p == top) ? POS_W'(1) : POS_W'(p + 6'd1);
  endfunction

  function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [POS_W-1:0] top;
    top = POS_W'(n - 7'd1);
    return (p == POS_W'(1)) ? top : POS_W'(p - 6'd1);
  endfunction

endpackage

[src/tpm_front.sv]
// Front end: accepts items, holds the tour length, wraps positions into commands.
module tpm_front #(
  parameter int MAX_CITIES = tpm_pkg::DEF_MAX_CITIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [tpm_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [1:0]                 kind,
  input  logic [tpm_pkg::GENE_W-1:0] gene_value,
  input  logic [tpm_pkg::POS_W-1:0]  pos_a,
  input  logic [tpm_pkg::POS_W-1:0]  pos_b,
  input  logic [tpm_pkg::POS_W-1:0]  block_len,
  output logic                       q_push,
  output tpm_pkg::cmd_t              q_data,
  input  logic                       q_full
);
  import tpm_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t     state;
  cmd_t             cmd;
  logic [CNT_W-1:0] city_count;
  logic [CNT_W-1:0] n_sat;
  logic [2:0]       step;
  logic [CNT_W-1:0] rem      [3];
  logic [CNT_W-1:0] rem_next [3];
  logic [POS_W-1:0] wrp      [3];
  logic [2:0]       zero;
  logic [POS_W-1:0] dm1;
  logic [11:0]      dsh;
  logic [CNT_W-1:0] x_in     [3];

  always_comb begin
    if (city_count < MIN_CITIES) begin
      n_sat = MIN_CITIES;
    end else if (city_count > CNT_W'(MAX_CITIES)) begin
      n_sat = CNT_W'(MAX_CITIES);
    end else begin
      n_sat = city_count;
    end
  end

  assign x_in[0] = {1'b0, pos_a};
  assign x_in[1] = {1'b0, pos_b};
  assign x_in[2] = CNT_W'({1'b0, pos_a} + {1'b0, block_len} - 7'd1);

  assign dm1 = POS_W'(cmd.n - 7'd1);
  assign dsh = 12'(dm1) << step;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_next[i] = ({5'b0, rem[i]} >= dsh) ? CNT_W'(rem[i] - dsh[CNT_W-1:0]) : rem[i];
      wrp[i]      = zero[i] ? dm1 : POS_W'(rem_next[i] + 7'd1);
    end
  end

  assign item_ready = (state == F_IDLE);
  assign q_push     = (state == F_PUSH) && !q_full;
  assign q_data     = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RST;
    end else if (cfg_write) begin
      city_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (item_valid) begin
            cmd.gene     <= gene_value;
            cmd.load_pos <= pos_a;
            cmd.n        <= n_sat;
            cmd.len      <= (kind == KIND_PAIR) ? POS_W'(1) : block_len;
            step         <= 3'(MOD_STEPS - 1);
            for (int i = 0; i < 3; i++) begin
              rem[i]  <= CNT_W'(x_in[i] - 7'd1);
              zero[i] <= (x_in[i] == '0);
            end
            case (kind)
              KIND_LOAD: begin
                cmd.op <= OP_LOAD;
                state  <= F_PUSH;
              end
              KIND_PAIR: begin
                cmd.op  <= OP_SWAP;
                state   <= F_CALC;
              end
              KIND_BLOCK: begin
                cmd.op <= OP_SWAP;
                state  <= F_CALC;
              end
              default: begin
                cmd.op <= OP_INV;
                state  <= F_CALC;
              end
            endcase
          end
        end
        F_CALC: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= rem_next[i];
          end
          step <= step - 3'd1;
          if (step == '0) begin
            cmd.wa <= wrp[0];
            cmd.wb <= wrp[1];
            cmd.wi <= wrp[2];
            state  <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_wa_range: assert property (@(posedge clk) disable iff (rst)
    q_push && (q_data.op != OP_LOAD) |-> (q_data.wa != '0) && ({1'b0, q_data.wa} < q_data.n))
    else $error("first wrapped position out of range");
  a_wb_range: assert property (@(posedge clk) disable iff (rst)
    q_push && (q_data.op != OP_LOAD) |-> (q_data.wb != '0) && ({1'b0, q_data.wb} < q_data.n))
    else $error("second wrapped position out of range");
  a_wi_range: assert property (@(posedge clk) disable iff (rst)
    q_push && (q_data.op == OP_INV) |-> (q_data.wi != '0) && ({1'b0, q_data.wi} < q_data.n))
    else $error("inversion source position out of range");
`endif

endmodule

[src/tpm_queue.sv]
// Short command queue between front and back ends.
module tpm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tpm_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tpm_pkg::cmd_t pop_data
);
  import tpm_pkg::*;

  localparam int AW = $clog2(CQ_DEPTH);

  cmd_t        mem [CQ_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   cnt;

  assign full     = (cnt == (AW+1)'(CQ_DEPTH));
  assign valid    = (cnt != '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

[src/tpm_back.sv]
// Back end: parent store, child source map, gene emission and result buffer.
module tpm_back #(
  parameter int MAX_CITIES = tpm_pkg::DEF_MAX_CITIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  tpm_pkg::cmd_t              q_data,
  output logic                       q_pop,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [tpm_pkg::POS_W-1:0]  position,
  output logic [tpm_pkg::GENE_W-1:0] gene,
  output logic                       last
);
  import tpm_pkg::*;

  localparam int IW   = $clog2(MAX_CITIES);
  localparam int OQAW = $clog2(OQ_DEPTH);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_SWAP_A = 5'b00010,
    B_SWAP_B = 5'b00100,
    B_INV    = 5'b01000,
    B_EMIT   = 5'b10000
  } back_state_t;

  back_state_t       state;
  logic [GENE_W-1:0] parent_mem [MAX_CITIES];
  logic [POS_W-1:0]  map_mem    [MAX_CITIES];
  logic [MAX_CITIES-1:0] mv;

  logic [POS_W-1:0]  pa, pb, ps, remaining, k;
  logic [CNT_W-1:0]  n;
  logic              k_last;

  logic              map_we;
  logic [IW-1:0]     map_waddr;
  logic [POS_W-1:0]  map_wdata;
  logic              ld_we;
  logic              op_start;
  logic              issue;

  logic              s1_v, s1_last, s1_hit;
  logic [POS_W-1:0]  s1_pos, s1_src;
  logic [IW-1:0]     s1_raddr;
  logic              s2_v, s2_last;
  logic [POS_W-1:0]  s2_pos;
  logic [GENE_W-1:0] s2_gene;

  res_t              oq [OQ_DEPTH];
  logic [OQAW-1:0]   oq_wptr, oq_rptr;
  logic [OQAW:0]     oq_cnt;
  logic              oq_pop;

  assign q_pop    = (state == B_IDLE) && q_valid && !s1_v && !s2_v;
  assign ld_we    = q_pop && (q_data.op == OP_LOAD) &&
                    ({1'b0, q_data.load_pos} < CNT_W'(MAX_CITIES));
  assign op_start = q_pop && (q_data.op != OP_LOAD);
  assign k_last   = ({1'b0, k} == CNT_W'(n - 7'd1));
  assign issue    = (state == B_EMIT) &&
                    ((4'(oq_cnt) + 4'(s1_v) + 4'(s2_v)) < 4'(OQ_DEPTH));

  always_comb begin
    map_we    = 1'b0;
    map_waddr = pa[IW-1:0];
    map_wdata = pb;
    case (state)
      B_SWAP_A: map_we = 1'b1;
      B_SWAP_B: begin
        map_we    = 1'b1;
        map_waddr = pb[IW-1:0];
        map_wdata = pa;
      end
      B_INV: begin
        map_we    = 1'b1;
        map_wdata = ps;
      end
      default: map_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      parent_mem[q_data.load_pos[IW-1:0]] <= q_data.gene;
    end
    s2_gene <= parent_mem[s1_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    s1_src <= map_mem[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      mv    <= '0;
    end else begin
      if (op_start) begin
        mv <= '0;
      end else if (map_we) begin
        mv[map_waddr] <= 1'b1;
      end
      case (state)
        B_IDLE: begin
          if (op_start) begin
            pa        <= q_data.wa;
            pb        <= q_data.wb;
            ps        <= q_data.wi;
            remaining <= q_data.len;
            n         <= q_data.n;
            k         <= '0;
            if (q_data.len == '0) begin
              state <= B_EMIT;
            end else if (q_data.op == OP_SWAP) begin
              state <= B_SWAP_A;
            end else begin
              state <= B_INV;
            end
          end
        end
        B_SWAP_A: state <= B_SWAP_B;
        B_SWAP_B: begin
          pa        <= pos_inc(pa, n);
          pb        <= pos_inc(pb, n);
          remaining <= remaining - 6'd1;
          state     <= (remaining == POS_W'(1)) ? B_EMIT : B_SWAP_A;
        end
        B_INV: begin
          pa        <= pos_inc(pa, n);
          ps        <= pos_dec(ps, n);
          remaining <= remaining - 6'd1;
          if (remaining == POS_W'(1)) state <= B_EMIT;
        end
        B_EMIT: begin
          if (issue) begin
            k <= k + 6'd1;
            if (k_last) state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign s1_raddr = s1_hit ? s1_src[IW-1:0] : s1_pos[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
    end
    if (issue) begin
      s1_pos  <= k;
      s1_last <= k_last;
      s1_hit  <= mv[k[IW-1:0]];
    end
    s2_pos  <= s1_pos;
    s2_last <= s1_last;
  end

  assign oq_pop       = result_valid && result_ready;
  assign result_valid = (oq_cnt != '0);
  assign position     = oq[oq_rptr].pos;
  assign gene         = oq[oq_rptr].gene;
  assign last         = oq[oq_rptr].last;

  always_ff @(posedge clk) begin
    if (s2_v) begin
      oq[oq_wptr] <= '{pos: s2_pos, gene: s2_gene, last: s2_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr <= '0;
      oq_rptr <= '0;
      oq_cnt  <= '0;
    end else begin
      if (s2_v)   oq_wptr <= oq_wptr + 1'b1;
      if (oq_pop) oq_rptr <= oq_rptr + 1'b1;
      oq_cnt <= oq_cnt + (OQAW+1)'(s2_v) - (OQAW+1)'(oq_pop);
    end
  end

`ifndef ASSERT_OFF
  a_oq_room: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> (oq_cnt < (OQAW+1)'(OQ_DEPTH)) || oq_pop)
    else $error("result buffer overrun");
  a_pipe_flow: assert property (@(posedge clk) disable iff (rst)
    s1_v |=> s2_v)
    else $error("read pipeline dropped an item");
  a_map_addr: assert property (@(posedge clk) disable iff (rst)
    map_we |-> (map_waddr != '0) && (CNT_W'(map_waddr) < n))
    else $error("map write outside tour");
`endif

endmodule

[src/tour_permutation_mutation.sv]
// Top level of the tour mutation block: front end, command queue, back end.
// Load item: wrapped into a command, queued, then written to the parent store; no result.
// Operation item: the front end wraps positions, the back end writes the map twice per block
// gene for a swap or once per gene for an inversion, then emits n genes at one per cycle while
// the result buffer has room. The front end can take the next item while the back end is busy.
// Reset clears control and sets city_count to 64; the parent tour is undefined until loaded.
module tour_permutation_mutation #(
  parameter int MAX_CITIES = tpm_pkg::DEF_MAX_CITIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [tpm_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [1:0]                 kind,
  input  logic [tpm_pkg::GENE_W-1:0] gene_value,
  input  logic [tpm_pkg::POS_W-1:0]  pos_a,
  input  logic [tpm_pkg::POS_W-1:0]  pos_b,
  input  logic [tpm_pkg::POS_W-1:0]  block_len,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [tpm_pkg::POS_W-1:0]  position,
  output logic [tpm_pkg::GENE_W-1:0] gene,
  output logic                       last
);
  import tpm_pkg::*;

  logic push, full, pop, qv;
  cmd_t push_data, pop_data;

  tpm_front #(.MAX_CITIES(MAX_CITIES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .gene_value (gene_value),
    .pos_a      (pos_a),
    .pos_b      (pos_b),
    .block_len  (block_len),
    .q_push     (push),
    .q_data     (push_data),
    .q_full     (full)
  );

  tpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .valid     (qv),
    .pop_data  (pop_data)
  );

  tpm_back #(.MAX_CITIES(MAX_CITIES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (qv),
    .q_data       (pop_data),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .position     (position),
    .gene         (gene),
    .last         (last)
  );

endmodule

[dv/tb_top.sv]
// Testbench for tour_permutation_mutation: predicts each child tour and checks every gene.
module tb_top;
  import tpm_pkg::*;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int DRAIN_CYCLES  = 50_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LOAD_SETTLE   = 20;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 40;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  class child_tour_board;
    logic [GENE_W-1:0] parent_copy [DEF_MAX_CITIES];
    logic [CNT_W-1:0]  city_count;
    res_t              child_genes_due [$];
    int                mismatches;
    int                genes_checked;
    int                kinds_seen [4];

    function new();
      foreach (parent_copy[i]) parent_copy[i] = '0;
      foreach (kinds_seen[i]) kinds_seen[i] = 0;
      city_count    = CITY_COUNT_RST;
      mismatches    = 0;
      genes_checked = 0;
    endfunction

    function int tour_len();
      int n;
      n = int'(city_count);
      if (n < int'(MIN_CITIES)) n = int'(MIN_CITIES);
      if (n > DEF_MAX_CITIES) n = DEF_MAX_CITIES;
      return n;
    endfunction

    function int wrap_tour(int x, int n);
      if (x == 0) return n - 1;
      return ((x - 1) % (n - 1)) + 1;
    endfunction

    function int pending();
      return child_genes_due.size();
    endfunction

    // Applies one accepted item: loads update the parent, operations queue the child tour.
    function void note_item(logic [1:0] k, logic [GENE_W-1:0] g, logic [POS_W-1:0] a,
                            logic [POS_W-1:0] b, logic [POS_W-1:0] m);
      logic [GENE_W-1:0] child [DEF_MAX_CITIES];
      int n, pa, pb, ia, ib, im;
      res_t r;
      kinds_seen[k]++;
      if (k == KIND_LOAD) begin
        parent_copy[a] = g;
        return;
      end
      n  = tour_len();
      ia = int'(a);
      ib = int'(b);
      im = int'(m);
      child = parent_copy;
      case (k)
        KIND_PAIR: begin
          pa = wrap_tour(ia, n);
          pb = wrap_tour(ib, n);
          child[pa] = parent_copy[pb];
          child[pb] = parent_copy[pa];
        end
        KIND_BLOCK: begin
          for (int j = 0; j < im; j++) begin
            pa = wrap_tour(ia + j, n);
            pb = wrap_tour(ib + j, n);
            child[pa] = parent_copy[pb];
            child[pb] = parent_copy[pa];
          end
        end
        default: begin
          for (int j = 0; j < im; j++)
            child[wrap_tour(ia + j, n)] = parent_copy[wrap_tour(ia + im - 1 - j, n)];
        end
      endcase
      for (int j = 0; j < n; j++) begin
        r.pos  = POS_W'(j);
        r.gene = child[j];
        r.last = (j == n - 1);
        child_genes_due.insert(child_genes_due.size(), r);
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_gene(logic [POS_W-1:0] p, logic [GENE_W-1:0] g, logic l);
      res_t want;
      genes_checked++;
      if (child_genes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected gene %0d at position %0d", g, p));
        return;
      end
      want = child_genes_due.pop_front();
      if (p !== want.pos)
        flag_mismatch($sformatf("position %0d, want %0d", p, want.pos));
      if (g !== want.gene)
        flag_mismatch($sformatf("gene %0d at position %0d, want %0d", g, want.pos, want.gene));
      if (l !== want.last)
        flag_mismatch($sformatf("last %0b at position %0d, want %0b", l, want.pos, want.last));
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [CNT_W-1:0]  cfg_wdata;
  logic              item_valid;
  logic              item_ready;
  logic [1:0]        kind;
  logic [GENE_W-1:0] gene_value;
  logic [POS_W-1:0]  pos_a;
  logic [POS_W-1:0]  pos_b;
  logic [POS_W-1:0]  block_len;
  logic              result_valid;
  logic              result_ready;
  logic [POS_W-1:0]  position;
  logic [GENE_W-1:0] gene;
  logic              last;

  child_tour_board board;
  int              send_idle_pct;
  int              recv_stall_pct;
  int unsigned     cycle_count;

  tour_permutation_mutation DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .gene_value   (gene_value),
    .pos_a        (pos_a),
    .pos_b        (pos_b),
    .block_len    (block_len),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .position     (position),
    .gene         (gene),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && result_ready === 1'b1)
        board.check_gene(position, gene, last);
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Called at a clock edge; returns at the edge where the item was accepted.
  task automatic send_item(logic [1:0] k, logic [GENE_W-1:0] g, logic [POS_W-1:0] a,
                           logic [POS_W-1:0] b, logic [POS_W-1:0] m);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    gene_value <= g;
    pos_a      <= a;
    pos_b      <= b;
    block_len  <= m;
    @(posedge clk);
    while (item_ready !== 1'b1) @(posedge clk);
    board.note_item(k, g, a, b, m);
  endtask

  task automatic wait_children_done();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_city_count(logic [CNT_W-1:0] v);
    wait_children_done();
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.city_count = v;
  endtask

  task automatic send_random_item();
    logic [1:0]        k;
    logic [GENE_W-1:0] g;
    logic [POS_W-1:0]  a;
    logic [POS_W-1:0]  b;
    logic [POS_W-1:0]  m;
    int                top;
    int                sel;
    top = board.tour_len() - 1;
    if ($urandom_range(0, 39) == 0) wait_children_done();
    k = ($urandom_range(0, 4) == 0) ? KIND_LOAD : 2'($urandom_range(1, 3));
    g = GENE_W'($urandom);
    a = ($urandom_range(0, 2) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(1, top));
    b = ($urandom_range(0, 2) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(1, top));
    sel = $urandom_range(0, 9);
    if (sel == 0) m = POS_W'($urandom);
    else if (sel == 1) m = '0;
    else m = POS_W'($urandom_range(1, (top + 1) / 2));
    if (k == KIND_LOAD) a = POS_W'($urandom);
    send_item(k, g, a, b, m);
  endtask

  initial begin
    logic [CNT_W-1:0] counts [PHASES];
    int               waited;
    idle_mode_t       mode;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_wdata  <= '0;
    item_valid <= 1'b0;
    kind       <= KIND_LOAD;
    gene_value <= '0;
    pos_a      <= '0;
    pos_b      <= '0;
    block_len  <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    board = new();
    counts = '{7'd4, 7'd0, 7'd127, 7'd3, 7'd64, 7'd5, 7'd0, 7'd37};
    counts[6] = CNT_W'($urandom_range(6, 63));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full parent first, so no operation ever reads an unloaded entry
    for (int p = 0; p < DEF_MAX_CITIES; p++)
      send_item(KIND_LOAD, GENE_W'(p + 1), POS_W'(p), '0, '0);

    send_item(KIND_PAIR,  7'd0,   6'd1,  6'd63, 6'd0);
    send_item(KIND_PAIR,  7'd127, 6'd0,  6'd63, 6'd63);
    send_item(KIND_PAIR,  7'd0,   6'd5,  6'd5,  6'd0);
    send_item(KIND_BLOCK, 7'd0,   6'd1,  6'd10, 6'd5);
    send_item(KIND_BLOCK, 7'd0,   6'd3,  6'd5,  6'd6);
    send_item(KIND_BLOCK, 7'd0,   6'd7,  6'd20, 6'd0);
    send_item(KIND_BLOCK, 7'd0,   6'd63, 6'd0,  6'd63);
    send_item(KIND_INV,   7'd0,   6'd1,  6'd0,  6'd63);
    send_item(KIND_INV,   7'd0,   6'd9,  6'd0,  6'd0);
    send_item(KIND_INV,   7'd0,   6'd62, 6'd0,  6'd1);
    send_item(KIND_INV,   7'd0,   6'd60, 6'd0,  6'd10);
    send_item(KIND_LOAD,  7'd127, 6'd0,  6'd0,  6'd0);
    send_item(KIND_LOAD,  7'd0,   6'd63, 6'd63, 6'd63);
    send_item(KIND_PAIR,  7'd0,   6'd63, 6'd62, 6'd0);
    send_item(KIND_INV,   7'd0,   6'd0,  6'd0,  6'd3);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_city_count(counts[ph]);
      mode = idle_mode_t'(ph % 4);
      case (mode)
        IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SEND: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default:   begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
    end

    item_valid <= 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.flag_mismatch($sformatf("%0d child genes never arrived", board.pending()));

    $display("Covered %0d loads, %0d pair swaps, %0d block swaps, %0d inversions; %0d genes checked",
             board.kinds_seen[KIND_LOAD], board.kinds_seen[KIND_PAIR],
             board.kinds_seen[KIND_BLOCK], board.kinds_seen[KIND_INV], board.genes_checked);
    $display("Tour lengths 4 to 64 incl. out-of-range counts 0, 3, 127; %0d mismatches",
             board.mismatches);
    if (board.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[tour_permutation_mutation.f]
src/tpm_pkg.sv
src/tpm_front.sv
src/tpm_queue.sv
src/tpm_back.sv
src/tour_permutation_mutation.sv
dv/tb_top.sv
